// File: design/klt_pkg.sv
`timescale 1ns / 1ps
package klt_pkg;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_SPECIAL = 2'd1,
    KIND_IGNORED = 2'd2
  } kind_t;

  localparam logic [3:0] SK_F10   = 4'd0;
  localparam logic [3:0] SK_LEFT  = 4'd1;
  localparam logic [3:0] SK_RIGHT = 4'd2;
  localparam logic [3:0] SK_UP    = 4'd3;
  localparam logic [3:0] SK_DOWN  = 4'd4;
  localparam logic [3:0] SK_DEL   = 4'd5;
  localparam logic [3:0] SK_END   = 4'd6;
  localparam logic [3:0] SK_HOME  = 4'd7;
  localparam logic [3:0] SK_PGUP  = 4'd8;
  localparam logic [3:0] SK_PGDN  = 4'd9;
  localparam logic [3:0] SK_ESC   = 4'd10;
  localparam logic [3:0] SK_MAX   = SK_ESC;

  localparam logic [1:0] LAYOUT_QWERTY = 2'd0;
  localparam logic [1:0] LAYOUT_AZERTY = 2'd1;
  localparam logic [1:0] LAYOUT_DVORAK = 2'd2;

  localparam logic [7:0] FIRST_PRINT = 8'h20;
  localparam logic [7:0] LAST_PRINT  = 8'h7e;
  localparam int         ROM_DEPTH   = 95;

  // Result of the first stage: everything but the layout remap.
  typedef struct packed {
    kind_t      kind;
    logic [3:0] sk;
    logic [7:0] ch;
    logic       use_rom;
  } cls_t;

  localparam logic [7:0] DVORAK_ROM [0:ROM_DEPTH-1] = '{
    8'h20, 8'h21, 8'h5f, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2d,
    8'h28, 8'h29, 8'h2a, 8'h7d, 8'h77, 8'h5b, 8'h76, 8'h7a,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h53, 8'h73, 8'h57, 8'h5d, 8'h56, 8'h5a,
    8'h40, 8'h41, 8'h58, 8'h4a, 8'h45, 8'h3e, 8'h55, 8'h49,
    8'h44, 8'h43, 8'h48, 8'h54, 8'h4e, 8'h4d, 8'h42, 8'h52,
    8'h4c, 8'h22, 8'h50, 8'h4f, 8'h59, 8'h47, 8'h4b, 8'h3c,
    8'h51, 8'h46, 8'h3a, 8'h2f, 8'h5c, 8'h3d, 8'h5e, 8'h7b,
    8'h60, 8'h61, 8'h78, 8'h6a, 8'h65, 8'h2e, 8'h75, 8'h69,
    8'h64, 8'h63, 8'h68, 8'h74, 8'h6e, 8'h6d, 8'h62, 8'h72,
    8'h6c, 8'h27, 8'h70, 8'h6f, 8'h79, 8'h67, 8'h6b, 8'h2c,
    8'h71, 8'h66, 8'h3b, 8'h3f, 8'h7c, 8'h2b, 8'h7e
  };

  localparam logic [7:0] AZERTY_ROM [0:ROM_DEPTH-1] = '{
    8'h20, 8'h31, 8'h25, 8'h33, 8'h34, 8'h35, 8'h37, 8'hf9,
    8'h39, 8'h30, 8'h38, 8'h2b, 8'h3b, 8'h29, 8'h3a, 8'h21,
    8'he0, 8'h26, 8'he9, 8'h22, 8'h27, 8'h28, 8'h2d, 8'he8,
    8'h5f, 8'he7, 8'h4d, 8'h6d, 8'h2e, 8'h3d, 8'h2f, 8'ha7,
    8'h32, 8'h51, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
    8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h3f, 8'h4e, 8'h4f,
    8'h50, 8'h41, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h5a,
    8'h58, 8'h59, 8'h57, 8'h5e, 8'h5c, 8'h24, 8'h36, 8'hb0,
    8'hb2, 8'h71, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
    8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h2c, 8'h6e, 8'h6f,
    8'h70, 8'h61, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h7a,
    8'h78, 8'h79, 8'h77, 8'h7b, 8'h7c, 8'h7d, 8'h7e
  };

endpackage

// File: design/keystroke_layout_translator_top.sv
`timescale 1ns / 1ps
// Keystroke layout translator.
// Input channel: in_valid / in_stall with in_scan_code, in_char_in and
// in_ctrl_held. Result channel: out_valid / out_stall with out_result_kind,
// out_char_out and out_special_key; exactly one result per keystroke.
// Configuration: cfg_valid / cfg_ready writes the two-bit keyboard layout
// (0 qwerty, 1 azerty, 2 dvorak, 3 behaves as qwerty). cfg_ready is always
// high; write only while no keystroke is in flight.
// An accepted keystroke passes three registers in order: a classify stage,
// a layout-remap stage and the output register, which drives out_valid.
// One keystroke is accepted every cycle when the receiver does not stall;
// the rate is set by the three-stage pipeline, each stage holding one
// transaction.
// When out_stall is high the output holds, and the stages behind it keep
// filling until every stage is occupied; then in_stall rises. No transaction
// is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and sets the layout to
// qwerty.
module keystroke_layout_translator_top
  import klt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_scan_code,
  input  logic [7:0] in_char_in,
  input  logic       in_ctrl_held,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_char_out,
  output logic [3:0] out_special_key,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  logic [1:0] layout_r;
  cls_t       cls_nxt;
  cls_t       s1_r;
  logic       v1_r, v2_r, v3_r;
  kind_t      kind2_r, kind3_r;
  logic [7:0] ch2_r, ch3_r;
  logic [3:0] sk2_r, sk3_r;
  logic [7:0] ch2_nxt;
  logic [6:0] rom_idx;
  logic       rdy1, rdy2, rdy3;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= LAYOUT_QWERTY;
    end else if (cfg_valid && cfg_ready) begin
      layout_r <= cfg_data;
    end
  end

  assign rdy3     = !v3_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  klt_classify u_classify (
    .scan_code (in_scan_code),
    .char_in   (in_char_in),
    .ctrl_held (in_ctrl_held),
    .cls       (cls_nxt)
  );

  // Stage 1: classified keystroke.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_r <= cls_nxt;
    end
  end

  // Only printable bytes reach the remap, so the offset fits in seven bits.
  assign rom_idx = s1_r.ch[6:0] - FIRST_PRINT[6:0];

  always_comb begin
    ch2_nxt = s1_r.ch;
    if (s1_r.use_rom) begin
      case (layout_r)
        LAYOUT_DVORAK: ch2_nxt = DVORAK_ROM[rom_idx];
        LAYOUT_AZERTY: ch2_nxt = AZERTY_ROM[rom_idx];
        default:       ch2_nxt = s1_r.ch;
      endcase
    end
  end

  // Stage 2: remapped result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      kind2_r <= s1_r.kind;
      ch2_r   <= ch2_nxt;
      sk2_r   <= s1_r.sk;
    end
  end

  // Stage 3: output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      kind3_r <= kind2_r;
      ch3_r   <= ch2_r;
      sk3_r   <= sk2_r;
    end
  end

  assign out_valid       = v3_r;
  assign out_result_kind = kind3_r;
  assign out_char_out    = ch3_r;
  assign out_special_key = sk3_r;

endmodule

// File: design/klt_classify.sv
`timescale 1ns / 1ps
module klt_classify
  import klt_pkg::*;
(
  input  logic [7:0] scan_code,
  input  logic [7:0] char_in,
  input  logic       ctrl_held,
  output cls_t       cls
);

  logic       scan_hit;
  logic [3:0] scan_sk;
  logic       ctrl_hit;
  logic [3:0] ctrl_sk;
  logic [7:0] cc;

  always_comb begin
    scan_hit = 1'b1;
    case (scan_code)
      8'h44:   scan_sk = SK_F10;
      8'h4b:   scan_sk = SK_LEFT;
      8'h4d:   scan_sk = SK_RIGHT;
      8'h48:   scan_sk = SK_UP;
      8'h50:   scan_sk = SK_DOWN;
      8'h53:   scan_sk = SK_DEL;
      8'h4f:   scan_sk = SK_END;
      8'h47:   scan_sk = SK_HOME;
      8'h49:   scan_sk = SK_PGUP;
      8'h51:   scan_sk = SK_PGDN;
      8'h01:   scan_sk = SK_ESC;
      default: begin
        scan_sk  = SK_F10;
        scan_hit = 1'b0;
      end
    endcase
  end

  // Control codes fold onto lower-case letters; otherwise the byte counts
  // only while control is held.
  always_comb begin
    if (char_in >= 8'h01 && char_in <= 8'h1a) begin
      cc = char_in | 8'h60;
    end else if (ctrl_held) begin
      cc = char_in;
    end else begin
      cc = 8'h00;
    end
  end

  always_comb begin
    ctrl_hit = 1'b1;
    case (cc)
      8'h61:   ctrl_sk = SK_HOME;
      8'h65:   ctrl_sk = SK_END;
      8'h70:   ctrl_sk = SK_UP;
      8'h6e:   ctrl_sk = SK_DOWN;
      8'h62:   ctrl_sk = SK_LEFT;
      8'h66:   ctrl_sk = SK_RIGHT;
      8'h78:   ctrl_sk = SK_F10;
      default: begin
        ctrl_sk  = SK_F10;
        ctrl_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    cls.kind    = KIND_CHAR;
    cls.sk      = 4'd0;
    cls.ch      = 8'h00;
    cls.use_rom = 1'b0;
    if (scan_hit) begin
      cls.kind = KIND_SPECIAL;
      cls.sk   = scan_sk;
    end else if (char_in == 8'h0a || char_in == 8'h0d) begin
      cls.ch = 8'h0a;
    end else if (char_in == 8'h08 || char_in == 8'h09) begin
      cls.ch = char_in;
    end else if (ctrl_hit) begin
      cls.kind = KIND_SPECIAL;
      cls.sk   = ctrl_sk;
    end else if (char_in < FIRST_PRINT || char_in > LAST_PRINT) begin
      cls.kind = KIND_IGNORED;
    end else begin
      cls.ch      = char_in;
      cls.use_rom = 1'b1;
    end
  end

endmodule

// File: design/klt_checker.sv
`timescale 1ns / 1ps
module klt_checker
  import klt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_result_kind,
  input logic [7:0] out_char_out,
  input logic [3:0] out_special_key
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind)
      && $stable(out_char_out) && $stable(out_special_key))
    else $error("stalled result changed");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind == KIND_CHAR || out_result_kind == KIND_SPECIAL
      || out_result_kind == KIND_IGNORED)
    else $error("illegal result kind");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != KIND_CHAR |-> out_char_out == 8'h00)
    else $error("character byte set on a non-character result");

  a_special_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_kind == KIND_SPECIAL && out_special_key <= SK_MAX)
      || (out_result_kind != KIND_SPECIAL && out_special_key == 4'd0))
    else $error("special key code out of place");

endmodule

bind keystroke_layout_translator_top klt_checker u_klt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_kind (out_result_kind),
  .out_char_out    (out_char_out),
  .out_special_key (out_special_key)
);

// File: tb/tb_keystroke_layout_translator_top.sv
`timescale 1ns / 1ps
module tb_keystroke_layout_translator_top;
  import klt_pkg::*;

  typedef struct packed {
    logic [7:0] scan;
    logic [7:0] ch;
    logic       ctrl;
  } keystroke_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic [3:0] sk;
  } translation_t;

  // BIOS scan codes of the navigation keys.
  localparam logic [7:0] SC_ESC  = 8'h01;
  localparam logic [7:0] SC_F10  = 8'h44;
  localparam logic [7:0] SC_HOME = 8'h47;
  localparam logic [7:0] SC_UP   = 8'h48;
  localparam logic [7:0] SC_PGUP = 8'h49;
  localparam logic [7:0] SC_LEFT = 8'h4b;
  localparam logic [7:0] SC_RGHT = 8'h4d;
  localparam logic [7:0] SC_END  = 8'h4f;
  localparam logic [7:0] SC_DOWN = 8'h50;
  localparam logic [7:0] SC_PGDN = 8'h51;
  localparam logic [7:0] SC_DEL  = 8'h53;
  localparam logic [7:0] SC_NONE = 8'h00;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_CTRL_LAST = 8'h1a;
  localparam logic [7:0] CH_PRINT_LO  = 8'h20;
  localparam logic [7:0] CH_PRINT_HI  = 8'h7e;

  localparam logic [1:0] LAYOUT_SPARE = 2'd3;

  localparam int LATENCY_SLACK    = 6;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int MAX_REPORTS      = 10;

  localparam logic [7:0] NAV_SCANS [0:10] = '{
    SC_ESC, SC_F10, SC_HOME, SC_UP, SC_PGUP, SC_LEFT, SC_RGHT, SC_END,
    SC_DOWN, SC_PGDN, SC_DEL
  };
  localparam logic [7:0] CTRL_LETTERS [0:6] = '{"a", "e", "p", "n", "b", "f", "x"};

  localparam logic [7:0] DVORAK_MAP [0:94] = '{
    8'h20, 8'h21, 8'h5f, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2d,
    8'h28, 8'h29, 8'h2a, 8'h7d, 8'h77, 8'h5b, 8'h76, 8'h7a,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h53, 8'h73, 8'h57, 8'h5d, 8'h56, 8'h5a,
    8'h40, 8'h41, 8'h58, 8'h4a, 8'h45, 8'h3e, 8'h55, 8'h49,
    8'h44, 8'h43, 8'h48, 8'h54, 8'h4e, 8'h4d, 8'h42, 8'h52,
    8'h4c, 8'h22, 8'h50, 8'h4f, 8'h59, 8'h47, 8'h4b, 8'h3c,
    8'h51, 8'h46, 8'h3a, 8'h2f, 8'h5c, 8'h3d, 8'h5e, 8'h7b,
    8'h60, 8'h61, 8'h78, 8'h6a, 8'h65, 8'h2e, 8'h75, 8'h69,
    8'h64, 8'h63, 8'h68, 8'h74, 8'h6e, 8'h6d, 8'h62, 8'h72,
    8'h6c, 8'h27, 8'h70, 8'h6f, 8'h79, 8'h67, 8'h6b, 8'h2c,
    8'h71, 8'h66, 8'h3b, 8'h3f, 8'h7c, 8'h2b, 8'h7e
  };

  localparam logic [7:0] AZERTY_MAP [0:94] = '{
    8'h20, 8'h31, 8'h25, 8'h33, 8'h34, 8'h35, 8'h37, 8'hf9,
    8'h39, 8'h30, 8'h38, 8'h2b, 8'h3b, 8'h29, 8'h3a, 8'h21,
    8'he0, 8'h26, 8'he9, 8'h22, 8'h27, 8'h28, 8'h2d, 8'he8,
    8'h5f, 8'he7, 8'h4d, 8'h6d, 8'h2e, 8'h3d, 8'h2f, 8'ha7,
    8'h32, 8'h51, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
    8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h3f, 8'h4e, 8'h4f,
    8'h50, 8'h41, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h5a,
    8'h58, 8'h59, 8'h57, 8'h5e, 8'h5c, 8'h24, 8'h36, 8'hb0,
    8'hb2, 8'h71, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
    8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h2c, 8'h6e, 8'h6f,
    8'h70, 8'h61, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h7a,
    8'h78, 8'h79, 8'h77, 8'h7b, 8'h7c, 8'h7d, 8'h7e
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_scan_code = '0;
  logic [7:0] in_char_in = '0;
  logic       in_ctrl_held = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_result_kind;
  logic [7:0] out_char_out;
  logic [3:0] out_special_key;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = '0;

  keystroke_t   pending_keystrokes[$];
  translation_t expected_translations[$];
  logic [1:0]   layout_setting = LAYOUT_QWERTY;
  int           send_gap_pct = 0;
  int           recv_stall_pct = 0;
  bit           long_hold_phase = 1'b0;
  int           hold_count = 0;
  int           fail_count = 0;
  int           accepted_keystrokes = 0;
  int           checked_results = 0;
  int           special_results = 0;
  int           ignored_results = 0;
  int           held_off_cycles = 0;

  keystroke_layout_translator_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_scan_code    (in_scan_code),
    .in_char_in      (in_char_in),
    .in_ctrl_held    (in_ctrl_held),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_char_out    (out_char_out),
    .out_special_key (out_special_key),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic translation_t translate_keystroke(input keystroke_t k,
                                                      input logic [1:0] layout);
    translation_t res;
    logic [7:0]   letter;
    logic         hit;
    res.kind = KIND_CHAR;
    res.ch = '0;
    res.sk = SK_F10;
    hit = 1'b1;
    case (k.scan)
      SC_F10:  res.sk = SK_F10;
      SC_LEFT: res.sk = SK_LEFT;
      SC_RGHT: res.sk = SK_RIGHT;
      SC_UP:   res.sk = SK_UP;
      SC_DOWN: res.sk = SK_DOWN;
      SC_DEL:  res.sk = SK_DEL;
      SC_END:  res.sk = SK_END;
      SC_HOME: res.sk = SK_HOME;
      SC_PGUP: res.sk = SK_PGUP;
      SC_PGDN: res.sk = SK_PGDN;
      SC_ESC:  res.sk = SK_ESC;
      default: hit = 1'b0;
    endcase
    if (hit) begin
      res.kind = KIND_SPECIAL;
      return res;
    end
    if (k.ch == CH_LF || k.ch == CH_CR) begin
      res.ch = CH_LF;
      return res;
    end
    if (k.ch == CH_BS || k.ch == CH_TAB) begin
      res.ch = k.ch;
      return res;
    end
    // A control code stands for its letter; otherwise ctrl must be held.
    if (k.ch >= 8'h01 && k.ch <= CH_CTRL_LAST) letter = k.ch | 8'h60;
    else if (k.ctrl) letter = k.ch;
    else letter = 8'h00;
    hit = 1'b1;
    case (letter)
      "a":     res.sk = SK_HOME;
      "e":     res.sk = SK_END;
      "p":     res.sk = SK_UP;
      "n":     res.sk = SK_DOWN;
      "b":     res.sk = SK_LEFT;
      "f":     res.sk = SK_RIGHT;
      "x":     res.sk = SK_F10;
      default: hit = 1'b0;
    endcase
    if (hit) begin
      res.kind = KIND_SPECIAL;
      return res;
    end
    if (k.ch < CH_PRINT_LO || k.ch > CH_PRINT_HI) begin
      res.kind = KIND_IGNORED;
      return res;
    end
    case (layout)
      LAYOUT_AZERTY: res.ch = AZERTY_MAP[k.ch - CH_PRINT_LO];
      LAYOUT_DVORAK: res.ch = DVORAK_MAP[k.ch - CH_PRINT_LO];
      default:       res.ch = k.ch;
    endcase
    return res;
  endfunction

  task automatic record_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  // Keystroke driver: a transaction completes when valid is high and stall low.
  always @(posedge clk) begin
    keystroke_t k;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) held_off_cycles++;
      if (!in_valid || !in_stall) begin
        if (in_valid) begin
          expected_translations.push_back(translate_keystroke(
              '{in_scan_code, in_char_in, in_ctrl_held}, layout_setting));
          accepted_keystrokes++;
        end
        if (pending_keystrokes.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          k = pending_keystrokes.pop_front();
          in_valid <= 1'b1;
          in_scan_code <= k.scan;
          in_char_in <= k.ch;
          in_ctrl_held <= k.ctrl;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with an optional long hold at the start of a phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_count <= 0;
    end else if (long_hold_phase && hold_count < LONG_HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      if (!long_hold_phase) hold_count <= 0;
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    translation_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_translations.size() == 0) begin
        record_failure($sformatf("unexpected result kind=%0d char=%02h key=%0d",
                                 out_result_kind, out_char_out, out_special_key));
      end else begin
        want = expected_translations.pop_front();
        checked_results++;
        if (want.kind == KIND_SPECIAL) special_results++;
        if (want.kind == KIND_IGNORED) ignored_results++;
        if (out_result_kind !== want.kind || out_char_out !== want.ch ||
            out_special_key !== want.sk) begin
          record_failure($sformatf(
              "result %0d: expected kind=%0d char=%02h key=%0d, got kind=%0d char=%02h key=%0d",
              checked_results, want.kind, want.ch, want.sk,
              out_result_kind, out_char_out, out_special_key));
        end
      end
    end
  end

  task automatic queue_keystroke(input logic [7:0] scan, input logic [7:0] ch,
                                 input logic ctrl);
    pending_keystrokes.push_back('{scan, ch, ctrl});
  endtask

  // Mostly plain typing, with navigation keys, control codes, ctrl letters
  // and high bytes mixed in.
  task automatic queue_random_keystrokes(input int count);
    logic [7:0] scan;
    logic [7:0] ch;
    int         pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) scan = NAV_SCANS[$urandom_range(0, 10)];
      else if (pick < 40) scan = 8'($urandom_range(0, 255));
      else scan = SC_NONE;
      pick = $urandom_range(0, 99);
      if (pick < 55) ch = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
      else if (pick < 70) ch = 8'($urandom_range(0, 31));
      else if (pick < 80) ch = 8'($urandom_range(128, 255));
      else ch = CTRL_LETTERS[$urandom_range(0, 6)];
      queue_keystroke(scan, ch, 1'($urandom_range(0, 1)));
    end
  endtask

  // Waits until every queued keystroke has been sent and answered.
  task automatic drain;
    @(negedge clk);
    while (pending_keystrokes.size() > 0 || in_valid || expected_translations.size() > 0)
      @(negedge clk);
    repeat (LATENCY_SLACK) @(negedge clk);
  endtask

  task automatic write_layout(input logic [1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    layout_setting = value;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [1:0] layout, input int gap_pct,
                           input int stall_pct, input int count);
    write_layout(layout);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    queue_random_keystrokes(count);
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed keystrokes at the reset layout.
    queue_keystroke(SC_F10, "q", 1'b0);
    queue_keystroke(SC_LEFT, 8'h00, 1'b1);
    queue_keystroke(SC_RGHT, 8'hff, 1'b0);
    queue_keystroke(SC_UP, "a", 1'b1);
    queue_keystroke(SC_DOWN, CH_CR, 1'b0);
    queue_keystroke(SC_DEL, "z", 1'b0);
    queue_keystroke(SC_END, 8'h7f, 1'b1);
    queue_keystroke(SC_HOME, CH_PRINT_HI, 1'b0);
    queue_keystroke(SC_PGUP, CH_PRINT_LO, 1'b0);
    queue_keystroke(SC_PGDN, 8'h05, 1'b0);
    queue_keystroke(SC_ESC, 8'h1b, 1'b0);
    queue_keystroke(SC_NONE, CH_CR, 1'b1);
    queue_keystroke(SC_NONE, CH_LF, 1'b0);
    queue_keystroke(SC_NONE, CH_BS, 1'b0);
    queue_keystroke(SC_NONE, CH_TAB, 1'b1);
    queue_keystroke(SC_NONE, 8'h01, 1'b0);
    queue_keystroke(SC_NONE, 8'h18, 1'b0);
    queue_keystroke(SC_NONE, CH_CTRL_LAST, 1'b0);
    queue_keystroke(SC_NONE, "e", 1'b1);
    queue_keystroke(SC_NONE, "p", 1'b1);
    queue_keystroke(SC_NONE, "E", 1'b1);
    queue_keystroke(SC_NONE, "1", 1'b1);
    queue_keystroke(SC_NONE, 8'h00, 1'b1);
    queue_keystroke(SC_NONE, 8'h1f, 1'b0);
    queue_keystroke(8'hff, 8'hff, 1'b1);
    queue_keystroke(SC_NONE, "a", 1'b0);
    drain();

    run_phase(LAYOUT_AZERTY, 0, 0, 250);
    run_phase(LAYOUT_DVORAK, 78, 0, 250);
    run_phase(LAYOUT_SPARE, 0, 78, 250);

    // The receiver holds off long enough for the pipeline to fill, and the
    // sender later pauses until every result is back.
    long_hold_phase = 1'b1;
    run_phase(LAYOUT_QWERTY, 13, 13, 125);
    queue_random_keystrokes(125);
    drain();
    long_hold_phase = 1'b0;

    run_phase(LAYOUT_AZERTY, 13, 13, 250);

    if (expected_translations.size() != 0)
      record_failure($sformatf("%0d results never arrived", expected_translations.size()));
    $display("Covered %0d keystrokes across qwerty, azerty, dvorak and layout code 3,",
             accepted_keystrokes);
    $display("checking %0d results (%0d special, %0d ignored); input held off %0d cycles.",
             checked_results, special_results, ignored_results, held_off_cycles);
    if (fail_count == 0) begin
      $display("tb_keystroke_layout_translator_top OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("tb_keystroke_layout_translator_top NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", expected_translations.size());
    $display("tb_keystroke_layout_translator_top NOT OK");
    $finish;
  end

endmodule

// File: files.f
design/klt_pkg.sv
design/klt_classify.sv
design/keystroke_layout_translator_top.sv
design/klt_checker.sv
tb/tb_keystroke_layout_translator_top.sv
